@@ rtl/spd_pkg.sv @@
// ----------------------------------------------------------------------------
// spd_pkg
// Types and constants shared by the serial packet deframer modules.
// ----------------------------------------------------------------------------
package spd_pkg;

  localparam int BYTE_W     = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int TIMEOUT_W  = 16;
  localparam int LIMIT_W    = 6;
  localparam int LEN_OUT_W  = 6;
  localparam int ELAPSED_W  = 17;

  // Input item kinds
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIMEOUT    = 3'd0,
    CFG_SYNC       = 3'd1,
    CFG_ESCAPE     = 3'd2,
    CFG_ESC_EN     = 3'd3,
    CFG_COPY_LIMIT = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    STAT_READY    = 2'd0,
    STAT_CHECKSUM = 2'd1,
    STAT_TIMEOUT  = 2'd2
  } stat_code_e;

  typedef enum logic [2:0] {
    ST_HUNT,
    ST_LEN,
    ST_DATA,
    ST_EMIT,
    ST_FETCH,
    ST_STAT
  } state_e;

  typedef struct packed {
    logic [TIMEOUT_W-1:0] timeout_ticks;
    logic [BYTE_W-1:0]    sync_byte;
    logic [BYTE_W-1:0]    escape_byte;
    logic                 escape_enable;
    logic [LIMIT_W-1:0]   copy_limit;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic       start;
    logic       esc_set;
    logic       take_byte;
    logic       len_load;
    logic       data_store;
    logic       tick;
    logic       set_status;
    stat_code_e code;
    logic       len_zero;
    logic       emit_init;
    logic       rd_issue;
    logic       load_payload;
    logic       load_status;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_tick;
    logic is_sync;
    logic is_esc;
    logic len_ok;
    logic at_end;
    logic sum_ok;
    logic timed_out;
    logic emit_done;
    logic out_free;
  } dp_stat_t;

endpackage

@@ rtl/spd_in_if.sv @@
// ----------------------------------------------------------------------------
// spd_in_if
// Input channel: one received byte or one time tick per beat.
// ----------------------------------------------------------------------------
interface spd_in_if;
  logic                      valid;
  logic                      ready;
  logic                      cmd;
  logic [spd_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, cmd, rx_byte, input ready);
  modport sink   (input valid, cmd, rx_byte, output ready);
endinterface

@@ rtl/spd_out_if.sv @@
// ----------------------------------------------------------------------------
// spd_out_if
// Result channel: one payload byte or one packet status per beat.
// ----------------------------------------------------------------------------
interface spd_out_if;
  logic                          valid;
  logic                          ready;
  logic                          is_status;
  logic [spd_pkg::BYTE_W-1:0]    payload_byte;
  logic [1:0]                    status_code;
  logic [spd_pkg::LEN_OUT_W-1:0] pkt_len;
  logic                          last;

  modport source (output valid, is_status, payload_byte, status_code, pkt_len, last,
                  input ready);
  modport sink   (input valid, is_status, payload_byte, status_code, pkt_len, last,
                  output ready);
endinterface

@@ rtl/spd_cfg.sv @@
// ----------------------------------------------------------------------------
// spd_cfg
// Configuration register file, write only, with reset values.
// ----------------------------------------------------------------------------
module spd_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [spd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [spd_pkg::CFG_DATA_W-1:0] cfg_data,
  output spd_pkg::cfg_t                  cfg
);
  import spd_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timeout_ticks <= '0;
      cfg.sync_byte     <= 8'h55;
      cfg.escape_byte   <= 8'h1B;
      cfg.escape_enable <= 1'b1;
      cfg.copy_limit    <= 6'd32;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TIMEOUT:    cfg.timeout_ticks <= cfg_data[TIMEOUT_W-1:0];
        CFG_SYNC:       cfg.sync_byte     <= cfg_data[BYTE_W-1:0];
        CFG_ESCAPE:     cfg.escape_byte   <= cfg_data[BYTE_W-1:0];
        CFG_ESC_EN:     cfg.escape_enable <= cfg_data[0];
        CFG_COPY_LIMIT: cfg.copy_limit    <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/spd_datapath.sv @@
// ----------------------------------------------------------------------------
// spd_datapath
// Unescaping, checksum, tick counter, payload memory and result register.
// ----------------------------------------------------------------------------
module spd_datapath #(
  parameter int MAX_PAYLOAD = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  spd_pkg::cfg_t                  cfg,
  input  spd_pkg::ctrl_cmd_t             cmd,
  output spd_pkg::dp_stat_t              stat,
  input  logic                           in_cmd,
  input  logic [spd_pkg::BYTE_W-1:0]     in_byte,
  input  logic                           res_ready,
  output logic                           res_valid,
  output logic                           res_is_status,
  output logic [spd_pkg::BYTE_W-1:0]     res_payload_byte,
  output logic [1:0]                     res_status_code,
  output logic [spd_pkg::LEN_OUT_W-1:0]  res_pkt_len,
  output logic                           res_last
);
  import spd_pkg::*;

  localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);
  localparam int IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  logic                 esc_pending;
  logic [ELAPSED_W-1:0] elapsed;
  logic [ELAPSED_W-1:0] elapsed_next;
  logic [BYTE_W-1:0]    sum;
  logic [BYTE_W-1:0]    sum_next;
  logic [BYTE_W-1:0]    eff_byte;
  logic [LEN_W-1:0]     decl_len;
  logic [LEN_W-1:0]     count;
  logic [LEN_W-1:0]     emit_cnt;
  logic [LEN_W-1:0]     rd_idx;
  stat_code_e           stat_code;
  logic                 len_zero;
  logic [BYTE_W-1:0]    payload_mem [MAX_PAYLOAD];
  logic [BYTE_W-1:0]    mem_q;
  logic [LEN_OUT_W-1:0] decl_len_out;

  assign decl_len_out = LEN_OUT_W'(decl_len);
  assign eff_byte     = (cfg.escape_enable && esc_pending) ? ~in_byte : in_byte;
  assign sum_next     = sum + eff_byte;
  assign elapsed_next = (elapsed == '1) ? elapsed : elapsed + 1'b1;

  always_comb begin
    stat.is_tick   = (in_cmd == CMD_TICK);
    stat.is_sync   = (in_byte == cfg.sync_byte);
    stat.is_esc    = cfg.escape_enable && (in_byte == cfg.escape_byte);
    stat.len_ok    = (eff_byte <= BYTE_W'(MAX_PAYLOAD));
    stat.at_end    = (count == decl_len);
    stat.sum_ok    = (sum_next == '0);
    stat.timed_out = (cfg.timeout_ticks != '0) &&
                     (elapsed_next > ELAPSED_W'(cfg.timeout_ticks));
    stat.emit_done = (rd_idx == emit_cnt);
    stat.out_free  = !res_valid || res_ready;
  end

  // Packet bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      esc_pending <= 1'b0;
      elapsed     <= '0;
      sum         <= '0;
      count       <= '0;
      rd_idx      <= '0;
      emit_cnt    <= '0;
    end else begin
      if (cmd.start) begin
        esc_pending <= 1'b0;
        elapsed     <= '0;
        sum         <= '0;
        count       <= '0;
      end
      if (cmd.esc_set) begin
        esc_pending <= 1'b1;
      end
      if (cmd.take_byte) begin
        sum <= sum_next;
        if (cfg.escape_enable) begin
          esc_pending <= 1'b0;
        end
      end
      if (cmd.data_store) begin
        count <= count + 1'b1;
      end
      if (cmd.tick) begin
        elapsed <= elapsed_next;
      end
      if (cmd.emit_init) begin
        rd_idx   <= '0;
        emit_cnt <= (decl_len_out < cfg.copy_limit) ? decl_len : LEN_W'(cfg.copy_limit);
      end
      if (cmd.rd_issue) begin
        rd_idx <= rd_idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.len_load) begin
      decl_len <= eff_byte[LEN_W-1:0];
    end
    if (cmd.set_status) begin
      stat_code <= cmd.code;
      len_zero  <= cmd.len_zero;
    end
  end

  // Payload memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (cmd.data_store) begin
      payload_mem[count[IDX_W-1:0]] <= eff_byte;
    end
    if (cmd.rd_issue) begin
      mem_q <= payload_mem[rd_idx[IDX_W-1:0]];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.load_payload || cmd.load_status) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_payload) begin
      res_is_status    <= 1'b0;
      res_payload_byte <= mem_q;
      res_status_code  <= STAT_READY;
      res_pkt_len      <= decl_len_out;
      res_last         <= 1'b0;
    end else if (cmd.load_status) begin
      res_is_status    <= 1'b1;
      res_payload_byte <= '0;
      res_status_code  <= stat_code;
      res_pkt_len      <= len_zero ? '0 : decl_len_out;
      res_last         <= 1'b1;
    end
  end

endmodule

@@ rtl/spd_ctrl.sv @@
// ----------------------------------------------------------------------------
// spd_ctrl
// Frame state machine: hunt for sync, take length and payload, emit results.
// ----------------------------------------------------------------------------
module spd_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_accept,
  input  spd_pkg::dp_stat_t   stat,
  output logic                in_ready,
  output spd_pkg::ctrl_cmd_t  cmd
);
  import spd_pkg::*;

  state_e state;
  state_e state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_HUNT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_HUNT: begin
        if (in_accept && !stat.is_tick && stat.is_sync) begin
          state_next = ST_LEN;
        end
      end
      ST_LEN: begin
        if (in_accept) begin
          if (stat.is_tick) begin
            if (stat.timed_out) state_next = ST_STAT;
          end else if (!stat.is_esc) begin
            // drop an oversized length silently
            state_next = stat.len_ok ? ST_DATA : ST_HUNT;
          end
        end
      end
      ST_DATA: begin
        if (in_accept) begin
          if (stat.is_tick) begin
            if (stat.timed_out) state_next = ST_STAT;
          end else if (!stat.is_esc && stat.at_end) begin
            state_next = stat.sum_ok ? ST_EMIT : ST_STAT;
          end
        end
      end
      ST_EMIT:  state_next = stat.emit_done ? ST_STAT : ST_FETCH;
      ST_FETCH: if (stat.out_free) state_next = ST_EMIT;
      ST_STAT:  if (stat.out_free) state_next = ST_HUNT;
      default:  state_next = ST_HUNT;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.code = STAT_READY;
    in_ready = 1'b0;
    unique case (state)
      ST_HUNT: begin
        in_ready  = 1'b1;
        cmd.start = in_accept && !stat.is_tick && stat.is_sync;
      end
      ST_LEN, ST_DATA: begin
        in_ready = 1'b1;
        if (in_accept) begin
          if (stat.is_tick) begin
            cmd.tick = 1'b1;
            if (stat.timed_out) begin
              cmd.set_status = 1'b1;
              cmd.code       = STAT_TIMEOUT;
              cmd.len_zero   = (state == ST_LEN);
            end
          end else if (stat.is_esc) begin
            cmd.esc_set = 1'b1;
          end else begin
            cmd.take_byte = 1'b1;
            if (state == ST_LEN) begin
              cmd.len_load = 1'b1;
            end else if (stat.at_end) begin
              cmd.set_status = 1'b1;
              cmd.code       = stat.sum_ok ? STAT_READY : STAT_CHECKSUM;
              cmd.emit_init  = stat.sum_ok;
            end else begin
              cmd.data_store = 1'b1;
            end
          end
        end
      end
      ST_EMIT:  cmd.rd_issue     = !stat.emit_done;
      ST_FETCH: cmd.load_payload = stat.out_free;
      ST_STAT:  cmd.load_status  = stat.out_free;
      default: ;
    endcase
  end

endmodule

@@ rtl/serial_packet_deframer.sv @@
// ----------------------------------------------------------------------------
// serial_packet_deframer
// Sync / length / payload / checksum deframer with optional byte unescaping.
// ----------------------------------------------------------------------------
// Each input beat is one received byte or one time tick. The input is ready
// while the block hunts for sync or collects a packet; a status result
// left waiting in the output register does not hold off the next beat. When
// the checksum byte closes a packet the input is held off while results go
// out: each payload byte is read from the payload memory into a register
// and then loaded into the output register, and after the payload bytes the
// status result is loaded, each load waiting while the result side stalls.
// A bad checksum or a timeout holds the input until its status is loaded.
// Packets longer than MAX_PAYLOAD are dropped without a result.
module serial_packet_deframer #(
  parameter int MAX_PAYLOAD = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [spd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [spd_pkg::CFG_DATA_W-1:0] cfg_data,
  spd_in_if.sink                         item,
  spd_out_if.source                      result
);
  import spd_pkg::*;

  cfg_t      cfg;
  ctrl_cmd_t cmd;
  dp_stat_t  stat;
  logic      in_ready;
  logic      in_accept;

  assign item.ready = in_ready;
  assign in_accept  = item.valid && in_ready;

  spd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  spd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_accept (in_accept),
    .stat      (stat),
    .in_ready  (in_ready),
    .cmd       (cmd)
  );

  spd_datapath #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg              (cfg),
    .cmd              (cmd),
    .stat             (stat),
    .in_cmd           (item.cmd),
    .in_byte          (item.rx_byte),
    .res_ready        (result.ready),
    .res_valid        (result.valid),
    .res_is_status    (result.is_status),
    .res_payload_byte (result.payload_byte),
    .res_status_code  (result.status_code),
    .res_pkt_len      (result.pkt_len),
    .res_last         (result.last)
  );

endmodule

@@ rtl/spd_checker.sv @@
// ----------------------------------------------------------------------------
// spd_checker
// Port-level checks on the deframer, attached to the top level by bind.
// ----------------------------------------------------------------------------
module spd_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          item_ready,
  input logic                          res_valid,
  input logic                          res_ready,
  input logic                          res_is_status,
  input logic [spd_pkg::BYTE_W-1:0]    res_payload_byte,
  input logic [1:0]                    res_status_code,
  input logic [spd_pkg::LEN_OUT_W-1:0] res_pkt_len,
  input logic                          res_last
);

  // A stalled result beat holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid &&
      $stable({res_is_status, res_payload_byte, res_status_code, res_pkt_len, res_last}))
    else $error("result beat changed while stalled");

  // Input is held off while payload bytes go out
  a_no_input_in_burst: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_is_status |-> !item_ready)
    else $error("input taken during payload burst");

  // Payload beats belong to a nonempty packet and never end the run
  a_payload_shape: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_is_status |-> res_pkt_len != '0 && !res_last &&
      res_status_code == spd_pkg::STAT_READY)
    else $error("malformed payload beat");

  // Nothing is offered right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid after reset");

endmodule

bind serial_packet_deframer spd_checker u_spd_checker (
  .clk              (clk),
  .rst              (rst),
  .item_ready       (item.ready),
  .res_valid        (result.valid),
  .res_ready        (result.ready),
  .res_is_status    (result.is_status),
  .res_payload_byte (result.payload_byte),
  .res_status_code  (result.status_code),
  .res_pkt_len      (result.pkt_len),
  .res_last         (result.last)
);

@@ bench/serial_packet_deframer_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_packet_deframer_tb
// Self-checking bench for the sync / length / payload / checksum deframer.
// A queue-fed driver sends bytes and ticks, a clocked monitor predicts every
// payload and status result in order and compares each result beat field by
// field. Settings change between phases, with random idling on both sides.
// ----------------------------------------------------------------------------
module serial_packet_deframer_tb;
  import spd_pkg::*;

  localparam int MAX_LEN         = 32;
  localparam int DRAIN_CYCLES    = 2 * MAX_LEN + 8;
  localparam int STUCK_LIMIT     = 4000;
  localparam int RANDOM_PHASES   = 7;
  localparam int BEATS_PER_PHASE = 15;
  localparam logic [ELAPSED_W-1:0] TICKS_TOP = '1;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  typedef struct packed {
    logic              cmd;
    logic [BYTE_W-1:0] rx_byte;
  } serial_beat_t;

  typedef struct packed {
    logic                 is_status;
    logic [BYTE_W-1:0]    payload_byte;
    stat_code_e           status_code;
    logic [LEN_OUT_W-1:0] pkt_len;
    logic                 last;
  } deframe_result_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  spd_in_if  byte_in ();
  spd_out_if frame_out ();

  serial_packet_deframer #(.MAX_PAYLOAD(MAX_LEN)) DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (byte_in),
    .result    (frame_out)
  );

  // register copy
  logic [TIMEOUT_W-1:0] cfg_timeout    = '0;
  logic [BYTE_W-1:0]    cfg_sync       = 8'h55;
  logic [BYTE_W-1:0]    cfg_esc        = 8'h1B;
  logic                 cfg_esc_en     = 1'b1;
  logic [LIMIT_W-1:0]   cfg_copy_limit = 6'd32;

  // deframer state copy
  logic                 rx_active = 1'b0;
  logic [6:0]           rx_pos    = '0;
  logic [BYTE_W-1:0]    rx_len    = '0;
  logic                 esc_armed = 1'b0;
  logic [ELAPSED_W-1:0] tick_count = '0;
  logic [BYTE_W-1:0]    csum      = '0;
  logic [BYTE_W-1:0]    payload_buf [MAX_LEN];

  serial_beat_t    beat_fifo[$];
  deframe_result_t awaited_results[$];

  int  beats_queued = 0;
  int  beats_taken  = 0;
  int  err_count    = 0;
  int  stuck_cycles = 0;
  int  n_payload    = 0;
  int  n_ready      = 0;
  int  n_bad_sum    = 0;
  int  n_timeout    = 0;
  int  send_idle_pct = 0;
  int  stall_pct     = 0;
  logic in_beat = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ------------------------------------------------------------------
  // prediction
  // ------------------------------------------------------------------
  task automatic push_payload(input logic [BYTE_W-1:0] b);
    awaited_results.push_back('{1'b0, b, STAT_READY, rx_len[LEN_OUT_W-1:0], 1'b0});
  endtask

  task automatic push_status(input stat_code_e code, input logic [LEN_OUT_W-1:0] len);
    awaited_results.push_back('{1'b1, 8'h00, code, len, 1'b1});
  endtask

  task automatic deframe_beat(input logic cmd, input logic [BYTE_W-1:0] rx);
    logic [BYTE_W-1:0] b;
    int n_out;
    int i;
    b = rx;
    if (cmd == CMD_TICK) begin
      if (rx_active) begin
        if (tick_count != TICKS_TOP) tick_count++;
        if (cfg_timeout != 0 && tick_count > cfg_timeout) begin
          rx_active = 1'b0;
          push_status(STAT_TIMEOUT, (rx_pos >= 2) ? rx_len[LEN_OUT_W-1:0] : '0);
        end
      end
    end else if (!rx_active) begin
      if (b == cfg_sync) begin
        rx_active  = 1'b1;
        rx_pos     = 7'd1;
        tick_count = '0;
        csum       = '0;
        esc_armed  = 1'b0;
      end
    end else if (cfg_esc_en && b == cfg_esc) begin
      esc_armed = 1'b1;
    end else begin
      if (cfg_esc_en && esc_armed) begin
        b = ~b;
        esc_armed = 1'b0;
      end
      csum = csum + b;
      if (rx_pos == 7'd1) begin
        rx_len = b;
        if (int'(b) > MAX_LEN) rx_active = 1'b0;
        else rx_pos = 7'd2;
      end else if (int'(rx_pos) == int'(rx_len) + 2) begin
        rx_active = 1'b0;
        if (csum == 8'h00) begin
          n_out = (int'(rx_len) < int'(cfg_copy_limit)) ? int'(rx_len) : int'(cfg_copy_limit);
          for (i = 0; i < n_out && i < MAX_LEN; i++) push_payload(payload_buf[i]);
          push_status(STAT_READY, rx_len[LEN_OUT_W-1:0]);
        end else begin
          push_status(STAT_CHECKSUM, rx_len[LEN_OUT_W-1:0]);
        end
      end else begin
        if (int'(rx_pos) - 2 < MAX_LEN) payload_buf[int'(rx_pos) - 2] = b;
        rx_pos = rx_pos + 7'd1;
      end
    end
  endtask

  // ------------------------------------------------------------------
  // driver and receiver, both change at the falling edge
  // ------------------------------------------------------------------
  always @(negedge clk) begin
    serial_beat_t nxt;
    if (rst) begin
      byte_in.valid <= 1'b0;
    end else if (!byte_in.valid || in_beat) begin
      if (beat_fifo.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = beat_fifo.pop_front();
        byte_in.valid   <= 1'b1;
        byte_in.cmd     <= nxt.cmd;
        byte_in.rx_byte <= nxt.rx_byte;
      end else begin
        byte_in.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    frame_out.ready <= !rst && ($urandom_range(99) >= stall_pct);
  end

  // ------------------------------------------------------------------
  // monitor, checker and watchdog
  // ------------------------------------------------------------------
  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endfunction

  always @(posedge clk) begin
    deframe_result_t want;
    logic res_beat;
    logic cmd_beat;
    res_beat = frame_out.valid && frame_out.ready;
    cmd_beat = byte_in.valid && byte_in.ready;
    in_beat <= !rst && cmd_beat;
    if (!rst) begin
      if (res_beat) begin
        if (awaited_results.size() == 0) begin
          $error("unexpected result: is_status %0d byte %0d code %0d length %0d last %0d",
                 frame_out.is_status, frame_out.payload_byte, frame_out.status_code,
                 frame_out.pkt_len, frame_out.last);
          err_count++;
        end else begin
          want = awaited_results.pop_front();
          check_field("is_status", want.is_status, frame_out.is_status);
          check_field("payload_byte", want.payload_byte, frame_out.payload_byte);
          check_field("status_code", int'(want.status_code), frame_out.status_code);
          check_field("pkt_len", want.pkt_len, frame_out.pkt_len);
          check_field("last", want.last, frame_out.last);
          if (!want.is_status) n_payload++;
          else if (want.status_code == STAT_READY) n_ready++;
          else if (want.status_code == STAT_CHECKSUM) n_bad_sum++;
          else n_timeout++;
        end
      end
      if (cmd_beat) begin
        beats_taken++;
        deframe_beat(byte_in.cmd, byte_in.rx_byte);
      end
      stuck_cycles = (res_beat || cmd_beat) ? 0 : stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("no beat moved for %0d cycles", STUCK_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // ------------------------------------------------------------------
  // stimulus helpers
  // ------------------------------------------------------------------
  task automatic queue_beat(input logic cmd, input logic [BYTE_W-1:0] b);
    beat_fifo.push_back('{cmd, b});
    beats_queued++;
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    queue_beat(CMD_BYTE, b);
  endtask

  task automatic send_tick();
    queue_beat(CMD_TICK, 8'($urandom));
  endtask

  task automatic maybe_tick(input int pct);
    if ($urandom_range(99) < pct) send_tick();
  endtask

  // escape when required, sometimes when not, never when the inverted
  // value would itself look like an escape
  task automatic send_coded(input logic [BYTE_W-1:0] v);
    if (!cfg_esc_en || v == ~cfg_esc) begin
      send_byte(v);
    end else if (v == cfg_esc || $urandom_range(3) == 0) begin
      if ($urandom_range(7) == 0) send_byte(cfg_esc);
      send_byte(cfg_esc);
      send_byte(~v);
    end else begin
      send_byte(v);
    end
  endtask

  function automatic logic [BYTE_W-1:0] pick_data();
    case ($urandom_range(7))
      0: return cfg_sync;
      1: return cfg_esc;
      2: return ~cfg_esc;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic int pick_len();
    return ($urandom_range(11) == 0) ? $urandom_range(MAX_LEN, 7) : $urandom_range(6);
  endfunction

  task automatic send_packet(input int len, input logic corrupt, input int tick_pct);
    logic [BYTE_W-1:0] sum;
    logic [BYTE_W-1:0] v;
    int i;
    sum = 8'(len);
    send_byte(cfg_sync);
    maybe_tick(tick_pct);
    send_coded(8'(len));
    for (i = 0; i < len; i++) begin
      v = pick_data();
      sum = sum + v;
      maybe_tick(tick_pct);
      send_coded(v);
    end
    sum = 8'h00 - sum;
    if (corrupt) sum = sum + 8'($urandom_range(255, 1));
    maybe_tick(tick_pct);
    send_coded(sum);
  endtask

  task automatic cfg_write(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      CFG_TIMEOUT:    cfg_timeout    = data[TIMEOUT_W-1:0];
      CFG_SYNC:       cfg_sync       = data[BYTE_W-1:0];
      CFG_ESCAPE:     cfg_esc        = data[BYTE_W-1:0];
      CFG_ESC_EN:     cfg_esc_en     = data[0];
      CFG_COPY_LIMIT: cfg_copy_limit = data[LIMIT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic cfg_close();
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // upper bits are junk on purpose: the block keeps only the register width
  task automatic apply_setup(input logic [TIMEOUT_W-1:0] timeout, input logic [BYTE_W-1:0] sync,
                             input logic [BYTE_W-1:0] esc, input logic en,
                             input logic [LIMIT_W-1:0] limit);
    cfg_write(CFG_TIMEOUT, timeout);
    cfg_write(CFG_SYNC, {8'($urandom), sync});
    cfg_write(CFG_ESCAPE, {8'($urandom), esc});
    cfg_write(CFG_ESC_EN, {15'($urandom), en});
    cfg_write(CFG_COPY_LIMIT, {10'($urandom), limit});
    cfg_close();
  endtask

  task automatic settle();
    do @(negedge clk); while (beats_taken != beats_queued || awaited_results.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_idling(input idle_mode_e mode);
    case (mode)
      IDLE_NONE: begin send_idle_pct = 0;  stall_pct = 0;  end
      IDLE_SEND: begin send_idle_pct = 57; stall_pct = 0;  end
      IDLE_RECV: begin send_idle_pct = 0;  stall_pct = 57; end
      default:   begin send_idle_pct = 16; stall_pct = 16; end
    endcase
  endtask

  // ------------------------------------------------------------------
  // test sequence
  // ------------------------------------------------------------------
  initial begin
    logic [BYTE_W-1:0] chk;
    logic [BYTE_W-1:0] s;
    int ph;
    int i;
    int len;
    int mark;
    int tick_pct;
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_index       = CFG_TIMEOUT;
    cfg_data        = '0;
    byte_in.valid   = 1'b0;
    byte_in.cmd     = CMD_BYTE;
    byte_in.rx_byte = '0;
    frame_out.ready = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed, reset settings
    send_tick();
    send_byte(cfg_sync); send_byte(8'h00); send_byte(8'h00);
    // doubled escape, then sync value as plain data
    chk = 8'h00 - 8'd2 - 8'hFF - cfg_sync;
    send_byte(cfg_sync); send_byte(8'd2);
    send_byte(cfg_esc); send_byte(cfg_esc); send_byte(8'h00);
    send_byte(cfg_sync); send_byte(chk);
    send_byte(cfg_sync); send_byte(8'(MAX_LEN + 1));
    // length, payload and checksum all escaped
    send_byte(cfg_sync);
    send_byte(cfg_esc); send_byte(~8'd1);
    send_byte(cfg_esc); send_byte(~8'h80);
    send_byte(cfg_esc); send_byte(~8'h7F);
    send_byte(cfg_sync); send_byte(8'd1); send_byte(8'hA5); send_byte(8'h00);
    settle();

    // timeout before and after the length byte; spare indexes ignored
    apply_setup(16'd2, 8'h55, 8'h1B, 1'b1, 6'd0);
    for (i = int'(CFG_COPY_LIMIT) + 1; i < (1 << CFG_IDX_W); i++) begin
      @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data  <= '1;
    end
    cfg_close();
    send_byte(cfg_sync); send_tick(); send_tick(); send_tick();
    send_byte(cfg_sync); send_byte(8'd1); send_tick(); send_tick(); send_tick();
    settle();

    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      set_idling(idle_mode_e'(ph % 4));
      case (ph)
        0: apply_setup(16'd0, 8'h00, 8'hFF, 1'b1, 6'd32);
        1: apply_setup(16'd4, 8'hFF, 8'h00, 1'b1, 6'd0);
        2: apply_setup(16'd0, 8'($urandom), 8'($urandom), 1'b0, 6'($urandom_range(8, 1)));
        3: begin
          s = 8'($urandom);
          apply_setup(16'($urandom_range(12, 2)), s, s, 1'b1, 6'($urandom_range(MAX_LEN)));
        end
        default: apply_setup($urandom_range(1) ? 16'($urandom_range(12, 2)) : 16'd0,
                             8'($urandom), 8'($urandom), 1'($urandom),
                             6'($urandom_range(MAX_LEN)));
      endcase
      tick_pct = (cfg_timeout != 0) ? 8 : 15;
      mark = beats_queued;
      if (ph == 0) send_packet(MAX_LEN, 1'b0, 0);
      while (beats_queued - mark < BEATS_PER_PHASE) begin
        case ($urandom_range(19))
          0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12:
            send_packet(pick_len(), $urandom_range(6) == 0, tick_pct);
          13, 14: begin
            // noise while hunting, sync excluded
            repeat ($urandom_range(4, 1)) begin
              if ($urandom_range(3) == 0) send_tick();
              else begin
                s = 8'($urandom);
                send_byte((s == cfg_sync) ? s + 8'd1 : s);
              end
            end
          end
          15, 16: begin
            // packet cut short, then ticks
            len = pick_len();
            if (len == 0) len = 1;
            send_byte(cfg_sync);
            send_coded(8'(len));
            repeat ($urandom_range(len)) send_coded(pick_data());
            repeat ((cfg_timeout != 0 && cfg_timeout < 16'd12) ? int'(cfg_timeout) + 1 : 2)
              send_tick();
          end
          17, 18: begin
            send_byte(cfg_sync);
            send_coded($urandom_range(1) ? 8'hFF : 8'($urandom_range(254, MAX_LEN + 1)));
          end
          default: send_tick();
        endcase
      end
      settle();
    end

    $display("fed %0d beats over directed cases and %0d random phases",
             beats_taken, RANDOM_PHASES);
    $display("checked %0d payload bytes, %0d good, %0d bad-checksum, %0d timed-out packets",
             n_payload, n_ready, n_bad_sum, n_timeout);
    if (err_count == 0 && awaited_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/spd_pkg.sv
rtl/spd_in_if.sv
rtl/spd_out_if.sv
rtl/spd_cfg.sv
rtl/spd_datapath.sv
rtl/spd_ctrl.sv
rtl/serial_packet_deframer.sv
rtl/spd_checker.sv
bench/serial_packet_deframer_tb.sv
